### hdl/larprng_pkg.sv
// shared constants and helper functions for the lagged add-rotate generator
`default_nettype none
package larprng_pkg;

   // word and store geometry
   localparam int unsigned WordW    = 64;
   localparam int unsigned NumWords = 20;
   localparam int unsigned AddrW    = $clog2(NumWords);
   localparam int unsigned IdxW     = 4;

   // action codes carried on the request tuser
   localparam logic [1:0] ACT_REINIT = 2'd0;
   localparam logic [1:0] ACT_SEED   = 2'd1;
   localparam logic [1:0] ACT_GEN    = 2'd2;

   // seed used by reinit
   localparam logic [WordW-1:0] DEFAULT_SEED = 64'h0000_0000_8765_4321;

   // sequencer slots: three loads, twenty chain steps, a bubble, three output reads
   localparam int unsigned CntW = 5;
   localparam logic [CntW-1:0] CNT_LOAD_LAST = 5'd2;
   localparam logic [CntW-1:0] CNT_WRAP      = 5'd20;
   localparam logic [CntW-1:0] CNT_IDX_TAP   = 5'd19;
   localparam logic [CntW-1:0] CNT_SEED_LAST = 5'd22;
   localparam logic [CntW-1:0] CNT_BUBBLE    = 5'd23;
   localparam logic [CntW-1:0] CNT_OUT0      = 5'd24;
   localparam logic [CntW-1:0] CNT_OUT1      = 5'd25;
   localparam logic [CntW-1:0] CNT_OUT2      = 5'd26;

   // rotate left by a constant amount
   function automatic logic [WordW-1:0] rol64(input logic [WordW-1:0] v,
                                              input int unsigned n);
      rol64 = (v << n) | (v >> (WordW - n));
   endfunction

   // xorshift applied to the third word in xorshift mode
   function automatic logic [WordW-1:0] xsh64(input logic [WordW-1:0] v);
      logic [WordW-1:0] t;
      t = v ^ (v >> 15);
      t = t ^ (t << 13);
      t = t ^ (t >> 28);
      xsh64 = t;
   endfunction

endpackage
`default_nettype wire

### hdl/lagged_add_rotate_prng.sv
// Lagged add-rotate generator over twenty 64-bit words held in one on-chip RAM.
// Requests arrive as beats on req_*: req_tuser selects reinit, add seed or
// generate, req_tdata carries the seed value. Only generate returns a beat on
// rsp_*, holding the 64-bit random value in rsp_tdata. csr_wr_en writes the
// one-bit xorshift mode from csr_wr_data; the user must do so only while the
// block is idle, as the block itself does not enforce it. Each reinit, add
// seed or generate request walks the 27-slot sequencer through the word RAM
// (one read per cycle while it advances, data from a registered read): three
// reads of words 0..2 that add the seed, twenty chained add-xor-rotate steps,
// and for generate a bubble plus three reads of the output words. For generate,
// req_tready returns in the same cycle that rsp_tvalid rises. The chain carries
// x[k-1] into x[k], so the steps run one per cycle through the RAM port.
// The result sits in an output register; a stalled receiver only holds the
// next generate in its bubble slot until that register is free.
// Reset clears the valid bits of all words (so every word reads as zero),
// the mode register and all control; there is no clearing pass.
`default_nettype none
module lagged_add_rotate_prng (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [larprng_pkg::WordW-1:0] req_tdata,  // [63:0] seed_value
   input  wire logic [1:0]                    req_tuser,  // [1:0] action
   // result channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [larprng_pkg::WordW-1:0]      rsp_tdata,  // [63:0] random_value
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data
);
   import larprng_pkg::*;

   // control state
   logic                 run_ff, run_in;
   logic                 pend_ff;
   logic                 gen_ff;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [CntW-1:0]      pcnt_ff;
   logic                 mode_ff;
   logic [NumWords-1:0]  valid_ff;
   logic                 rvld_ff;
   logic                 rsp_valid_ff;

   // payload state
   logic [WordW-1:0]     seed_ff;
   logic [WordW-1:0]     b1_ff, b2_ff, b3_ff;
   logic [WordW-1:0]     t0_ff, t1_ff;
   logic [WordW-1:0]     rsp_data_ff;
   logic [IdxW-1:0]      idx_ff;
   logic [AddrW-1:0]     waddr_ff;
   logic [WordW-1:0]     mem_q_ff;
   logic [WordW-1:0]     mem [NumWords];

   // combinational signals
   logic                 req_acc;
   logic                 advance;
   logic                 rd_en;
   logic [AddrW-1:0]     raddr;
   logic                 wr_en;
   logic                 is_load;
   logic                 is_step;
   logic [WordW-1:0]     rd_word;
   logic [WordW-1:0]     addend;
   logic [WordW-1:0]     sum;
   logic [WordW-1:0]     val;
   logic [WordW-1:0]     third;
   logic [CntW-1:0]      last_cnt;
   logic [CntW-1:0]      out_ofs;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = !run_ff && !pend_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer advance, held in the bubble while the result register is full and not being taken
   assign advance  = run_ff && !(cnt_ff == CNT_BUBBLE && rsp_valid_ff && !rsp_tready);
   assign last_cnt = gen_ff ? CNT_OUT2 : CNT_SEED_LAST;
   assign out_ofs  = cnt_ff - CNT_OUT0;

   // read address per slot
   always_comb begin
      rd_en = advance;
      raddr = '0;
      case (cnt_ff) inside
         [5'd0:5'd19]: begin
            raddr = cnt_ff[AddrW-1:0];
         end
         [CNT_WRAP:CNT_SEED_LAST]: begin
            raddr = AddrW'(cnt_ff - CNT_WRAP);
         end
         [CNT_OUT0:CNT_OUT2]: begin
            raddr = AddrW'({1'b0, idx_ff} + out_ofs);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // returning read data, zero for words not written since reset or reinit
   assign rd_word = rvld_ff ? mem_q_ff : '0;

   // slot kind of the returning data
   assign is_load = pend_ff && (pcnt_ff <= CNT_LOAD_LAST);
   assign is_step = pend_ff && (pcnt_ff > CNT_LOAD_LAST) && (pcnt_ff <= CNT_SEED_LAST);
   assign wr_en   = is_load || is_step;

   // seed addend for the three loads
   always_comb begin
      case (pcnt_ff)
         5'd0:    addend = rol64(seed_ff, 1);
         5'd1:    addend = rol64(seed_ff, 21);
         5'd2:    addend = rol64(seed_ff, 42);
         default: addend = '0;
      endcase
   end

   // one add and xor per slot: seeding or one chain step
   assign sum   = rd_word + (is_step ? b3_ff : addend);
   assign val   = sum ^ (is_step ? rol64(b1_ff, 1) : '0);
   assign third = mode_ff ? xsh64(rd_word) : rol64(rd_word, 42);

   // next sequencer count and run flag
   always_comb begin
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (req_acc) begin
         cnt_in = '0;
         run_in = (req_tuser == ACT_REINIT) || (req_tuser == ACT_SEED)
                  || (req_tuser == ACT_GEN);
      end else if (advance) begin
         if (cnt_ff == last_cnt) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         gen_ff       <= 1'b0;
         cnt_ff       <= '0;
         pcnt_ff      <= '0;
         mode_ff      <= 1'b0;
         valid_ff     <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         pend_ff <= advance;
         pcnt_ff <= cnt_ff;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_acc) begin
            gen_ff <= (req_tuser == ACT_GEN);
         end
         if (rd_en) begin
            rvld_ff <= valid_ff[raddr];
         end
         if (req_acc && req_tuser == ACT_REINIT) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[waddr_ff] <= 1'b1;
         end
         if (pend_ff && pcnt_ff == CNT_OUT2) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         case (req_tuser)
            ACT_REINIT: seed_ff <= DEFAULT_SEED;
            ACT_SEED:   seed_ff <= req_tdata;
            default:    seed_ff <= '0;
         endcase
      end
      if (rd_en) begin
         waddr_ff <= raddr;
      end
      if (wr_en) begin
         b3_ff <= b2_ff;
         b2_ff <= b1_ff;
         b1_ff <= val;
      end
      if (is_step && pcnt_ff == CNT_IDX_TAP) begin
         idx_ff <= val[IdxW-1:0];
      end
      if (pend_ff && pcnt_ff == CNT_OUT0) begin
         t0_ff <= rol64(rd_word, 1);
      end
      if (pend_ff && pcnt_ff == CNT_OUT1) begin
         t1_ff <= rol64(rd_word, 21);
      end
      if (pend_ff && pcnt_ff == CNT_OUT2) begin
         rsp_data_ff <= (t0_ff + t1_ff) ^ third;
      end
   end

   // word RAM, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr_ff] <= val;
      end
      if (rd_en) begin
         mem_q_ff <= mem[raddr];
      end
   end

   // the RAM is never read and written at the same word in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (waddr_ff != raddr))
      else $error("read and write collide on one word");

   // a result lands only in an empty or draining result register
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff && pcnt_ff == CNT_OUT2) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites an untaken beat");

   // a result beat appears only after the last output read of a generate
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff && gen_ff && pcnt_ff == CNT_OUT2))
      else $error("result beat without a generate");

   // the sequencer stays within its slots
   assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff <= CNT_OUT2))
      else $error("sequencer count out of range");

endmodule
`default_nettype wire

### verif/tb_lagged_add_rotate_prng.sv
// testbench for the lagged add-rotate generator: tracked state, scoreboard and stream drivers
`timescale 1ns / 100ps

module tb_lagged_add_rotate_prng;
   import larprng_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // cycles a seed or generate beat may still be in flight after the last result
   localparam int unsigned SettleCycles = 40;

   // tracks the twenty mix words and the values generate must return
   class larprng_tracker;
      logic [WordW-1:0] mix_state [NumWords];
      logic             shift_mode;
      logic [WordW-1:0] expected_values [$];
      int unsigned      errors;

      function new();
         clear_words();
         shift_mode = 1'b0;
         errors     = 0;
      endfunction

      function void clear_words();
         foreach (mix_state[k]) mix_state[k] = '0;
      endfunction

      function logic [WordW-1:0] rotl(logic [WordW-1:0] v, int unsigned n);
         logic [2*WordW-1:0] both;
         both = {v, v} << n;
         return both[2*WordW-1:WordW];
      endfunction

      // serial chain; each step reads the old value of its own word
      function void mix_pass();
         logic [WordW-1:0] lag3, lag2, lag1, x;
         int unsigned      k, slot;
         lag3 = mix_state[0];
         lag2 = mix_state[1];
         lag1 = mix_state[2];
         for (k = 0; k < NumWords; k++) begin
            slot            = (k + 3) % NumWords;
            x               = (mix_state[slot] + lag3) ^ rotl(lag1, 1);
            mix_state[slot] = x;
            lag3            = lag2;
            lag2            = lag1;
            lag1            = x;
         end
      endfunction

      function void absorb_seed(logic [WordW-1:0] v);
         mix_state[0] = mix_state[0] + rotl(v, 1);
         mix_state[1] = mix_state[1] + rotl(v, 21);
         mix_state[2] = mix_state[2] + rotl(v, 42);
         mix_pass();
      endfunction

      function logic [WordW-1:0] draw_value();
         int unsigned      base;
         logic [WordW-1:0] t0, t1, t2;
         mix_pass();
         base = mix_state[NumWords-1][3:0];
         t0   = rotl(mix_state[base], 1);
         t1   = rotl(mix_state[base+1], 21);
         t2   = mix_state[base+2];
         if (shift_mode) begin
            t2 = t2 ^ (t2 >> 15);
            t2 = t2 ^ (t2 << 13);
            t2 = t2 ^ (t2 >> 28);
         end else begin
            t2 = rotl(t2, 42);
         end
         return (t0 + t1) ^ t2;
      endfunction

      function void report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endfunction

      // accepted request beat
      function void note_request(logic [1:0] act, logic [WordW-1:0] v);
         case (act)
            ACT_REINIT: begin
               clear_words();
               absorb_seed(DEFAULT_SEED);
            end
            ACT_SEED: absorb_seed(v);
            ACT_GEN:  expected_values.push_back(draw_value());
            default: ;
         endcase
      endfunction

      // accepted result beat
      function void check_value(logic [WordW-1:0] got);
         logic [WordW-1:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("random_value %h with nothing pending", got));
         end else begin
            want = expected_values.pop_front();
            if (got !== want)
               report($sformatf("random_value got %h want %h", got, want));
         end
      endfunction

      function int unsigned pending();
         return expected_values.size();
      endfunction

      function void finish_check();
         foreach (expected_values[k])
            report($sformatf("random_value %h never returned", expected_values[k]));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [WordW-1:0] req_tdata = '0;   // [63:0] seed_value
   logic [1:0]  req_tuser   = ACT_REINIT;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [WordW-1:0] rsp_tdata;   // [63:0] random_value
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   larprng_tracker tracker = new();

   lagged_add_rotate_prng u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // beat monitors on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_value(rsp_tdata);
         if (csr_wr_en)
            tracker.shift_mode = csr_wr_data;
      end
   end

   // entered and left just after a falling edge; valid stays high on exit
   task automatic send_beat(input logic [1:0] act, input logic [WordW-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop sending until every generate has returned
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_mode(input logic m);
      hold_until_drained();
      repeat (SettleCycles) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [WordW-1:0] pick_seed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, WordW-1);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [1:0] pick_action();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)       return ACT_REINIT;
      else if (r < 33) return ACT_SEED;
      else if (r < 95) return ACT_GEN;
      else             return ACT_UNUSED;
   endfunction

   task automatic run_random(input int unsigned count, input int unsigned sidle,
                             input int unsigned ridle);
      int unsigned n;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (n = 0; n < count; n++) begin
         if (n == count / 2)
            hold_until_drained();
         send_beat(pick_action(), pick_seed());
      end
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("tb_lagged_add_rotate_prng: FAIL");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero state, ignored code, seed extremes, reinit, both modes
      send_beat(ACT_GEN, '0);
      send_beat(ACT_UNUSED, '1);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_SEED, '0);
      send_beat(ACT_GEN, '1);
      send_beat(ACT_SEED, '1);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_SEED, 64'h0000_0000_0000_0001);
      send_beat(ACT_SEED, 64'h8000_0000_0000_0000);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_REINIT, '1);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_GEN, '0);
      write_mode(1'b1);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(ACT_SEED, 64'h5555_5555_5555_5555);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_REINIT, '0);
      send_beat(ACT_GEN, '0);
      send_beat(ACT_UNUSED, '0);
      send_beat(ACT_GEN, '1);

      // random phases with changing stall profiles
      write_mode(1'b0);
      run_random(230, 23, 75);
      write_mode(1'b1);
      run_random(230, 75, 23);
      write_mode(1'b0);
      run_random(230, 0, 0);

      // drain and settle
      hold_until_drained();
      repeat (SettleCycles) @(posedge clock);
      tracker.finish_check();
      if (tracker.errors == 0)
         $display("tb_lagged_add_rotate_prng: PASS");
      else
         $display("tb_lagged_add_rotate_prng: FAIL");
      $finish;
   end

endmodule

### sim.f
hdl/larprng_pkg.sv
hdl/lagged_add_rotate_prng.sv
verif/tb_lagged_add_rotate_prng.sv
